@@ rtl/azr_pkg.sv @@
// Shared types, constants and saturating helpers for the z-to-normal rotation unit.
// Used by the front end, back end, top level and bench; depends on nothing.
package azr_pkg;

  localparam int unsigned VEC_W     = 32;
  localparam int unsigned NORM_W    = 32;
  localparam int unsigned EPS_W     = 31;
  localparam int unsigned ACC_W     = 64;
  localparam int unsigned DIV_STEPS = 64;
  localparam int unsigned KDIV_W    = 31;

  localparam logic signed [ACC_W-1:0] ACC_MAX    = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [ACC_W-1:0] ACC_MIN    = 64'sh8000_0000_0000_0000;
  localparam logic signed [ACC_W-1:0] ONE_SQ     = 64'sh1000_0000_0000_0000;
  localparam logic signed [ACC_W-1:0] ROUND_HALF = 64'sh0000_0000_2000_0000;
  localparam logic signed [NORM_W-1:0] NORM_ONE  = 32'sh4000_0000;
  localparam logic signed [VEC_W-1:0] VEC_MAX    = 32'sh7FFF_FFFF;
  localparam logic signed [VEC_W-1:0] VEC_MIN    = 32'sh8000_0000;

  // register index taken from the word address bit
  localparam logic REG_PARALLEL_EPS = 1'b0;

  typedef enum logic [1:0] {
    PATH_GENERAL      = 2'd0,
    PATH_PARALLEL     = 2'd1,
    PATH_ANTIPARALLEL = 2'd2
  } path_t;

  // item handed from the front end to the back end
  typedef struct packed {
    path_t                    path;
    logic signed [NORM_W-1:0] nx;
    logic signed [NORM_W-1:0] ny;
    logic [KDIV_W-1:0]        k;
    logic signed [ACC_W-1:0]  w;
    logic signed [ACC_W-1:0]  ax;
    logic signed [ACC_W-1:0]  ay;
    logic signed [ACC_W-1:0]  z1;
    logic signed [ACC_W-1:0]  pz;
    logic signed [VEC_W-1:0]  par_x;
    logic signed [VEC_W-1:0]  par_y;
    logic signed [VEC_W-1:0]  par_z;
  } q_item_t;

  // sideband carried alongside the divider
  typedef struct packed {
    path_t                    path;
    logic signed [NORM_W-1:0] nx;
    logic signed [NORM_W-1:0] ny;
    logic [KDIV_W-1:0]        k;
    logic                     wneg;
    logic signed [ACC_W-1:0]  ax;
    logic signed [ACC_W-1:0]  ay;
    logic signed [ACC_W-1:0]  sz;
    logic signed [VEC_W-1:0]  par_x;
    logic signed [VEC_W-1:0]  par_y;
    logic signed [VEC_W-1:0]  par_z;
  } side_t;

  typedef struct packed {
    path_t                   path;
    logic signed [VEC_W-1:0] rz;
    logic signed [VEC_W-1:0] ry;
    logic signed [VEC_W-1:0] rx;
  } res_t;

  function automatic logic signed [ACC_W-1:0] sat66(input logic signed [ACC_W+1:0] a);
    logic signed [ACC_W-1:0] r;
    if (a[ACC_W+1:ACC_W-1] == 3'b000 || a[ACC_W+1:ACC_W-1] == 3'b111) begin
      r = a[ACC_W-1:0];
    end else if (a[ACC_W+1]) begin
      r = ACC_MIN;
    end else begin
      r = ACC_MAX;
    end
    return r;
  endfunction

  function automatic logic signed [ACC_W-1:0] sat97(input logic signed [96:0] a);
    logic signed [ACC_W-1:0] r;
    if ((&a[96:ACC_W-1]) || !(|a[96:ACC_W-1])) begin
      r = a[ACC_W-1:0];
    end else if (a[96]) begin
      r = ACC_MIN;
    end else begin
      r = ACC_MAX;
    end
    return r;
  endfunction

  function automatic logic signed [ACC_W+1:0] sext66(input logic signed [ACC_W-1:0] a);
    return {{2{a[ACC_W-1]}}, a};
  endfunction

  // negate with the most negative value mapped to the most positive
  function automatic logic signed [VEC_W-1:0] vec_neg(input logic signed [VEC_W-1:0] v);
    logic signed [VEC_W-1:0] r;
    if (v == VEC_MIN) begin
      r = VEC_MAX;
    end else begin
      r = -v;
    end
    return r;
  endfunction

  // Q46 sum to Q16: round half up, then saturate to the vector width
  function automatic logic signed [VEC_W-1:0] finish_q16(input logic signed [ACC_W-1:0] s);
    logic signed [ACC_W-1:0] r;
    logic signed [VEC_W-1:0] q;
    r = sat66(sext66(s) + sext66(ROUND_HALF));
    if (r[63:61] == 3'b000 || r[63:61] == 3'b111) begin
      q = r[61:30];
    end else if (r[63]) begin
      q = VEC_MIN;
    end else begin
      q = VEC_MAX;
    end
    return q;
  endfunction

endpackage

@@ rtl/azr_fifo.sv @@
// Two-entry item queue with registered ready, used between front and back end
// and at the result port. Depends on nothing.
module azr_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);

  logic [WIDTH-1:0] slot_r [2];
  logic             wr_ptr_r, rd_ptr_r;
  logic [1:0]       count_r, count_nxt;
  logic             push, pop;

  assign in_ready  = (count_r != 2'd2);
  assign out_valid = (count_r != 2'd0);
  assign out_data  = slot_r[rd_ptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      count_r <= count_nxt;
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= in_data;
  end

endmodule

@@ rtl/azr_front.sv @@
// Front end: takes input items, forms all vector-by-normal products, classifies
// the normal as parallel, antiparallel or general. Depends on azr_pkg.
module azr_front
  import azr_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [191:0]       in_data,
  input  logic [EPS_W-1:0]   eps,
  output logic               q_valid,
  input  logic               q_ready,
  output q_item_t            q_item
);

  logic signed [VEC_W-1:0]  vx, vy, vz;
  logic signed [NORM_W-1:0] nx, ny, nz;
  logic                     front_adv;

  logic                     a_v_r;
  logic signed [VEC_W-1:0]  vx_r, vy_r, vz_r;
  logic signed [NORM_W-1:0] nx_r, ny_r, nz_r;
  logic signed [ACC_W-1:0]  p_nzvx_r, p_nxvz_r, p_nzvy_r, p_nyvz_r;
  logic signed [ACC_W-1:0]  p_nxvx_r, p_nyvy_r, p_nzvz_r, p_nyvx_r, p_nxvy_r;
  logic signed [ACC_W-1:0]  nz2_r;
  logic [2*EPS_W-1:0]       eps2_r;

  logic signed [ACC_W-1:0]  gap_sq;
  logic                     par_hit;
  logic                     anti;
  logic signed [NORM_W-1:0] k_full;

  assign vx = in_data[31:0];
  assign vy = in_data[63:32];
  assign vz = in_data[95:64];
  assign nx = in_data[127:96];
  assign ny = in_data[159:128];
  assign nz = in_data[191:160];

  assign front_adv = !a_v_r || q_ready;
  assign in_ready  = front_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (front_adv) begin
      a_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (front_adv && in_valid) begin
      vx_r     <= vx;
      vy_r     <= vy;
      vz_r     <= vz;
      nx_r     <= nx;
      ny_r     <= ny;
      nz_r     <= nz;
      p_nzvx_r <= nz * vx;
      p_nxvz_r <= nx * vz;
      p_nzvy_r <= nz * vy;
      p_nyvz_r <= ny * vz;
      p_nxvx_r <= nx * vx;
      p_nyvy_r <= ny * vy;
      p_nzvz_r <= nz * vz;
      p_nyvx_r <= ny * vx;
      p_nxvy_r <= nx * vy;
      nz2_r    <= nz * nz;
      eps2_r   <= eps * eps;
    end
  end

  // sine test made exactly on squares: 1 - nz^2 <= eps^2
  assign gap_sq  = ONE_SQ - nz2_r;
  assign par_hit = $signed(gap_sq) <= $signed({2'b00, eps2_r});
  assign anti    = nz_r[NORM_W-1];
  assign k_full  = NORM_ONE + nz_r;

  always_comb begin
    q_item.path = PATH_GENERAL;
    if (par_hit) begin
      q_item.path = anti ? PATH_ANTIPARALLEL : PATH_PARALLEL;
    end
    q_item.nx    = nx_r;
    q_item.ny    = ny_r;
    q_item.k     = k_full[KDIV_W-1:0];
    q_item.w     = sat66(sext66(p_nyvx_r) - sext66(p_nxvy_r));
    q_item.ax    = sat66(sext66(p_nzvx_r) + sext66(p_nxvz_r));
    q_item.ay    = sat66(sext66(p_nzvy_r) + sext66(p_nyvz_r));
    q_item.z1    = sat66(sext66(-p_nxvx_r) + sext66(-p_nyvy_r));
    q_item.pz    = p_nzvz_r;
    q_item.par_x = anti ? vec_neg(vx_r) : vx_r;
    q_item.par_y = anti ? vec_neg(vy_r) : vy_r;
    q_item.par_z = anti ? vec_neg(vz_r) : vz_r;
  end

  assign q_valid = a_v_r;

endmodule

@@ rtl/azr_back.sv @@
// Back end: restoring divider for w/k (one quotient bit per stage), the
// saturating products with the quotient, final sums and rounding. Depends on azr_pkg.
module azr_back
  import azr_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    q_valid,
  output logic    q_ready,
  input  q_item_t q_item,
  output logic    o_valid,
  input  logic    o_ready,
  output res_t    o_item
);

  logic back_en;

  logic                    d_v_r    [DIV_STEPS+1];
  logic [KDIV_W-1:0]       d_rem_r  [DIV_STEPS+1];
  logic [ACC_W-1:0]        d_num_r  [DIV_STEPS+1];
  side_t                   d_side_r [DIV_STEPS+1];

  side_t                   entry_side;
  logic [ACC_W-1:0]        entry_mag;

  logic                    m1_v_r;
  side_t                   m1_side_r;
  logic signed [ACC_W-1:0] m1_nyh_r, m1_nxh_r;
  logic signed [ACC_W:0]   m1_nyl_r, m1_nxl_r;

  logic                    m2_v_r;
  side_t                   m2_side_r;
  logic signed [ACC_W-1:0] m2_cx_r, m2_cy_r;

  logic                    s1_v_r;
  side_t                   s1_side_r;
  logic signed [ACC_W-1:0] s1_sx_r, s1_sy_r;

  logic                    f_v_r;
  res_t                    f_res_r;

  logic [ACC_W-1:0]        quo;
  logic signed [ACC_W-1:0] t_sgn;
  logic signed [31:0]      t_hi;
  logic signed [32:0]      t_lo;
  logic signed [96:0]      ny_t, nx_t;
  res_t                    f_res_nxt;

  // the whole back end advances together while the result queue has room
  assign back_en = o_ready;
  assign q_ready = back_en;

  always_comb begin
    entry_side.path  = q_item.path;
    entry_side.nx    = q_item.nx;
    entry_side.ny    = q_item.ny;
    entry_side.k     = q_item.k;
    entry_side.wneg  = q_item.w[ACC_W-1];
    entry_side.ax    = q_item.ax;
    entry_side.ay    = q_item.ay;
    entry_side.sz    = sat66(sext66(q_item.z1) + sext66(q_item.pz));
    entry_side.par_x = q_item.par_x;
    entry_side.par_y = q_item.par_y;
    entry_side.par_z = q_item.par_z;
    entry_mag = q_item.w[ACC_W-1] ? ACC_W'(-q_item.w) : ACC_W'(q_item.w);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_v_r[0] <= 1'b0;
    end else if (back_en) begin
      d_v_r[0] <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (back_en) begin
      d_rem_r[0]  <= '0;
      d_num_r[0]  <= entry_mag;
      d_side_r[0] <= entry_side;
    end
  end

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    logic [KDIV_W:0] trial;
    logic [KDIV_W:0] kx;
    logic            ge;

    assign trial = {d_rem_r[i], d_num_r[i][ACC_W-1]};
    assign kx    = {1'b0, d_side_r[i].k};
    assign ge    = trial >= kx;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        d_v_r[i+1] <= 1'b0;
      end else if (back_en) begin
        d_v_r[i+1] <= d_v_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (back_en) begin
        d_rem_r[i+1]  <= ge ? KDIV_W'(trial - kx) : trial[KDIV_W-1:0];
        d_num_r[i+1]  <= {d_num_r[i][ACC_W-2:0], ge};
        d_side_r[i+1] <= d_side_r[i];
      end
    end
  end

  // signed quotient, truncated toward zero; split for two 32-bit products
  assign quo   = d_num_r[DIV_STEPS];
  assign t_sgn = d_side_r[DIV_STEPS].wneg ? $signed(-quo) : $signed(quo);
  assign t_hi  = t_sgn[63:32];
  assign t_lo  = {1'b0, t_sgn[31:0]};

  assign ny_t = {m1_nyh_r[ACC_W-1], m1_nyh_r, 32'h0} + {{32{m1_nyl_r[ACC_W]}}, m1_nyl_r};
  assign nx_t = {m1_nxh_r[ACC_W-1], m1_nxh_r, 32'h0} + {{32{m1_nxl_r[ACC_W]}}, m1_nxl_r};

  always_comb begin
    f_res_nxt.path = s1_side_r.path;
    if (s1_side_r.path == PATH_GENERAL) begin
      f_res_nxt.rx = finish_q16(s1_sx_r);
      f_res_nxt.ry = finish_q16(s1_sy_r);
      f_res_nxt.rz = finish_q16(s1_side_r.sz);
    end else begin
      f_res_nxt.rx = s1_side_r.par_x;
      f_res_nxt.ry = s1_side_r.par_y;
      f_res_nxt.rz = s1_side_r.par_z;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_v_r <= 1'b0;
      m2_v_r <= 1'b0;
      s1_v_r <= 1'b0;
      f_v_r  <= 1'b0;
    end else if (back_en) begin
      m1_v_r <= d_v_r[DIV_STEPS];
      m2_v_r <= m1_v_r;
      s1_v_r <= m2_v_r;
      f_v_r  <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (back_en) begin
      m1_side_r <= d_side_r[DIV_STEPS];
      m1_nyh_r  <= d_side_r[DIV_STEPS].ny * t_hi;
      m1_nxh_r  <= d_side_r[DIV_STEPS].nx * t_hi;
      m1_nyl_r  <= d_side_r[DIV_STEPS].ny * t_lo;
      m1_nxl_r  <= d_side_r[DIV_STEPS].nx * t_lo;

      m2_side_r <= m1_side_r;
      m2_cx_r   <= sat97(ny_t);
      m2_cy_r   <= sat97(-nx_t);

      s1_side_r <= m2_side_r;
      s1_sx_r   <= sat66(sext66(m2_side_r.ax) + sext66(m2_cx_r));
      s1_sy_r   <= sat66(sext66(m2_side_r.ay) + sext66(m2_cy_r));

      f_res_r   <= f_res_nxt;
    end
  end

  assign o_valid = f_v_r;
  assign o_item  = f_res_r;

endmodule

@@ rtl/align_z_to_normal_rotation_unit.sv @@
// Top level of the z-to-normal rotation unit: configuration register, front end,
// item queue, divider back end and result queue. Depends on azr_pkg and all azr_ modules.
//
//  port group | direction | carries
//  in_*       | sink      | one vector and unit normal per item
//  out_*      | source    | one rotated vector and path code per item
//  cfg_*      | slave     | parallel_epsilon register at byte address 0
//
// Takes one item per cycle while no stall holds the input; each result passes through the
// 64-stage divider (one quotient bit per stage), then product, sum and rounding stages.
// Reset clears all valid flags and the queues and sets epsilon to 1.
// A stalled result port fills the result queue, then holds the back end, then
// the middle queue, and last the input; no item is dropped or repeated.
module align_z_to_normal_rotation_unit
  import azr_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [191:0] in_tdata,   // vec_x, vec_y, vec_z, norm_x, norm_y, norm_z
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [95:0]  out_tdata,  // rot_x, rot_y, rot_z
  output logic [1:0]   out_tuser,  // path_code
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  logic [EPS_W-1:0] eps_r;
  logic             cfg_wr;

  logic             fq_valid, fq_ready;
  q_item_t          fq_item;
  logic             bq_valid, bq_ready;
  logic [$bits(q_item_t)-1:0] bq_data;
  logic             ro_valid, ro_ready;
  res_t             ro_item;
  logic [$bits(res_t)-1:0] out_data;
  res_t             out_res;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= EPS_W'(1);
    end else if (cfg_wr && (cfg_paddr[2] == REG_PARALLEL_EPS)) begin
      eps_r <= cfg_pwdata[EPS_W-1:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_PARALLEL_EPS) ? {1'b0, eps_r} : 32'h0;

  azr_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_data  (in_tdata),
    .eps      (eps_r),
    .q_valid  (fq_valid),
    .q_ready  (fq_ready),
    .q_item   (fq_item)
  );

  azr_fifo #(.WIDTH($bits(q_item_t))) u_mid_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fq_valid),
    .in_ready  (fq_ready),
    .in_data   (fq_item),
    .out_valid (bq_valid),
    .out_ready (bq_ready),
    .out_data  (bq_data)
  );

  azr_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (bq_valid),
    .q_ready (bq_ready),
    .q_item  (q_item_t'(bq_data)),
    .o_valid (ro_valid),
    .o_ready (ro_ready),
    .o_item  (ro_item)
  );

  azr_fifo #(.WIDTH($bits(res_t))) u_out_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (ro_valid),
    .in_ready  (ro_ready),
    .in_data   (ro_item),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_data)
  );

  assign out_res   = res_t'(out_data);
  assign out_tdata = {out_res.rz, out_res.ry, out_res.rx};
  assign out_tuser = out_res.path;

endmodule

@@ bench/tb_top.sv @@
// Self-checking bench for align_z_to_normal_rotation_unit: random and directed items,
// an in-bench rotation predictor, bursty sender and stalling receiver. Needs azr_pkg.
module tb_top;
  import azr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [31:0] nz, ny, nx, vz, vy, vx;
  } rot_in_t;

  typedef struct packed {
    path_t              path;
    logic signed [31:0] rz, ry, rx;
  } rot_out_t;

  localparam int LATENCY   = 80;
  localparam int CYCLE_CAP = 400000;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [191:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [95:0]  out_tdata;
  logic [1:0]   out_tuser;
  logic         cfg_psel = 1'b0;
  logic         cfg_penable = 1'b0;
  logic         cfg_pwrite = 1'b0;
  logic [2:0]   cfg_paddr = '0;
  logic [31:0]  cfg_pwdata = '0;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  rot_in_t  pending_items[$];
  rot_out_t expected_rot[$];
  logic [30:0] eps_model = 31'd1;
  int  mismatches = 0;
  int  cycle_count = 0;
  int  burst_left = 0;
  int  gap_left = 0;
  int  hold_off = 0;
  bit  stall_req = 1'b0;
  bit  stall_done = 1'b0;

  align_z_to_normal_rotation_unit DUT (.*);

  always #5 clk = ~clk;

  // saturating arithmetic on 64-bit signed values, done in 128 bits
  function automatic logic signed [63:0] clip64(input logic signed [127:0] a);
    if (a > 128'sh7FFF_FFFF_FFFF_FFFF) return ACC_MAX;
    if (a < -128'sh8000_0000_0000_0000) return ACC_MIN;
    return a[63:0];
  endfunction

  function automatic logic signed [63:0] smul(input logic signed [63:0] a, b);
    logic signed [127:0] p;
    p = 128'(a) * 128'(b);
    return clip64(p);
  endfunction

  function automatic logic signed [63:0] sadd(input logic signed [63:0] a, b);
    return clip64(128'(a) + 128'(b));
  endfunction

  function automatic logic signed [31:0] round_q16(input logic signed [63:0] s);
    logic signed [63:0] r;
    logic signed [63:0] q;
    r = sadd(s, 64'sd1 <<< 29);
    q = r >>> 30;
    if (q > 64'sh7FFF_FFFF) return VEC_MAX;
    if (q < -64'sh8000_0000) return VEC_MIN;
    return q[31:0];
  endfunction

  function automatic logic signed [31:0] flip(input logic signed [31:0] v);
    return (v == VEC_MIN) ? VEC_MAX : -v;
  endfunction

  function automatic rot_out_t rotate_into_normal(input rot_in_t it);
    rot_out_t r;
    logic signed [63:0] vx, vy, vz, nx, ny, nz, d, e, k, w, t;
    vx = it.vx; vy = it.vy; vz = it.vz;
    nx = it.nx; ny = it.ny; nz = it.nz;
    e = {33'd0, eps_model};
    d = ONE_SQ - nz * nz;
    if (d <= e * e) begin
      if (nz < 0) begin
        r.rx = flip(it.vx); r.ry = flip(it.vy); r.rz = flip(it.vz);
        r.path = PATH_ANTIPARALLEL;
      end else begin
        r.rx = it.vx; r.ry = it.vy; r.rz = it.vz;
        r.path = PATH_PARALLEL;
      end
    end else begin
      k = (64'sd1 <<< 30) + nz;
      w = sadd(smul(ny, vx), -smul(nx, vy));
      t = w / k;
      r.rx = round_q16(sadd(sadd(smul(nz, vx), smul(nx, vz)), smul(ny, t)));
      r.ry = round_q16(sadd(sadd(smul(nz, vy), smul(ny, vz)), smul(-nx, t)));
      r.rz = round_q16(sadd(sadd(smul(-nx, vx), smul(-ny, vy)), smul(nz, vz)));
      r.path = PATH_GENERAL;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got, want);
    $display("MISMATCH %s: got %h want %h at cycle %0d", what, got, want, cycle_count);
    mismatches++;
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
      default: return $urandom;
    endcase
  endfunction

  // unit-ish normal from random direction, in Q1.30, or on some items random words
  function automatic rot_in_t rand_item();
    rot_in_t it;
    real a, b, c, m;
    it.vx = rand_word(); it.vy = rand_word(); it.vz = rand_word();
    if ($urandom_range(0, 9) < 8) begin
      a = real'($signed($urandom)) / 2.0**31;
      b = real'($signed($urandom)) / 2.0**31;
      c = real'($signed($urandom)) / 2.0**31;
      if ($urandom_range(0, 4) == 0) begin
        a = a * 1e-5; b = b * 1e-5;
      end
      m = $sqrt(a * a + b * b + c * c) + 1e-30;
      it.nx = $rtoi(a / m * 2.0**30);
      it.ny = $rtoi(b / m * 2.0**30);
      it.nz = $rtoi(c / m * 2.0**30);
    end else begin
      it.nx = rand_word(); it.ny = rand_word(); it.nz = rand_word();
    end
    return it;
  endfunction

  function automatic rot_in_t mk(input logic [31:0] vx, vy, vz, nx, ny, nz);
    rot_in_t it;
    it.vx = vx; it.vy = vy; it.vz = vz; it.nx = nx; it.ny = ny; it.nz = nz;
    return it;
  endfunction

  task automatic write_eps(input logic [30:0] value);
    @(posedge clk);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_paddr <= '0;
    cfg_pwdata <= {1'b0, value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    eps_model = value;
  endtask

  task automatic drain();
    while (pending_items.size() != 0 || expected_rot.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  // sender: bursts and gaps
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        expected_rot.push_back(rotate_into_normal(pending_items.pop_front()));
      end
      if (!(in_tvalid && !in_tready)) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_tvalid <= 1'b0;
        end else if ((in_tvalid && in_tready ? pending_items.size() : pending_items.size()) != 0)
        begin
          in_tvalid <= 1'b1;
          in_tdata <= pending_items[0];
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: own stall pattern plus one long hold-off on request
  always @(posedge clk) begin
    if (rst_n) begin
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        out_tready <= 1'b0;
      end else if (stall_req && !stall_done) begin
        stall_done <= 1'b1;
        hold_off <= 300;
        out_tready <= 1'b0;
      end else begin
        out_tready <= (cycle_count % 256 < 128) ? 1'b1 : ($urandom_range(0, 3) != 0);
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    rot_out_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_rot.size() == 0) begin
        report_mismatch("unexpected item", out_tdata[31:0], '0);
      end else begin
        want = expected_rot.pop_front();
        if (out_tdata[31:0] !== want.rx) report_mismatch("rot_x", out_tdata[31:0], want.rx);
        if (out_tdata[63:32] !== want.ry) report_mismatch("rot_y", out_tdata[63:32], want.ry);
        if (out_tdata[95:64] !== want.rz) report_mismatch("rot_z", out_tdata[95:64], want.rz);
        if (out_tuser !== want.path) report_mismatch("path_code", out_tuser, want.path);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_CAP) begin
      $display("align_z_to_normal_rotation_unit test failed");
      $finish;
    end
  end

  initial begin
    logic [30:0] eps_set[4];
    eps_set = '{31'd0, 31'h4000_0000, 31'd1 << 20, 31'h0123_4567};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    // directed: exact parallel, antiparallel, extremes, non-unit normals
    pending_items.push_back(mk(32'h0001_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                               0, 0, 32'h4000_0000));
    pending_items.push_back(mk(32'h8000_0000, 32'h7FFF_FFFF, 32'h0002_0000,
                               0, 0, 32'hC000_0000));
    pending_items.push_back(mk(32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                               32'h4000_0000, 0, 0));
    pending_items.push_back(mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                               32'h2D41_3CCD, 32'h2D41_3CCD, 0));
    pending_items.push_back(mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                               32'h8000_0000, 32'h8000_0000, 32'hC000_0001));
    pending_items.push_back(mk(32'h1234_5678, 32'hFEDC_BA98, 32'h0, 32'h7FFF_FFFF,
                               32'h7FFF_FFFF, 32'h7FFF_FFFF));
    pending_items.push_back(mk(32'hFFFF_FFFF, 32'h0, 32'h1, 32'h0, 32'h4000_0000,
                               32'h8000_0000));
    pending_items.push_back(mk(32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                               32'h0000_8000, 32'h0, 32'h3FFF_FFFF));
    pending_items.push_back(mk(32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                               32'h0000_8000, 32'h0, 32'hC000_0001));
    pending_items.push_back(mk(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0));
    drain();
    for (int phase = 0; phase < 4; phase++) begin
      write_eps(eps_set[phase]);
      repeat (400) pending_items.push_back(rand_item());
      if (phase == 1) stall_req = 1'b1;
      drain();
    end
    if (mismatches == 0) begin
      $display("align_z_to_normal_rotation_unit test passed");
    end else begin
      $display("align_z_to_normal_rotation_unit test failed");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
rtl/azr_pkg.sv
rtl/azr_fifo.sv
rtl/azr_front.sv
rtl/azr_back.sv
rtl/align_z_to_normal_rotation_unit.sv
bench/tb_top.sv
